### rtl/core/dss_pkg.sv
`timescale 1ns / 1ps

package dss_pkg;

   // Fixed field widths of the command and response words.
   localparam int DATA_W = 32;
   localparam int CMD_W  = 2;
   localparam int POS_W  = 5;
   localparam int CNT_W  = 5;
   localparam int STAT_W = 2;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PEEK   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_CHANGE = 2'd3;

   // Response status codes.
   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;
   localparam logic [STAT_W-1:0] ST_RANGE     = 2'd3;

   // Memory access strobes from the pointer logic to the shared array.
   typedef struct packed {
      logic wr;
      logic rd;
   } mem_ctl_type;

endpackage

### rtl/core/dss_mem.sv
`timescale 1ns / 1ps

module dss_mem #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic                       clock,
   input  dss_pkg::mem_ctl_type       ctl,
   input  logic [AW-1:0]              addr,
   input  logic [dss_pkg::DATA_W-1:0] wdata,
   output logic [dss_pkg::DATA_W-1:0] rdata
);

   // Single-port array with a registered read; entries hold no reset value.
   logic [dss_pkg::DATA_W-1:0] store_ff [DEPTH];
   logic [dss_pkg::DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr) begin
         store_ff[addr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd) begin
         rdata_ff <= store_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/core/dss_ctrl.sv
`timescale 1ns / 1ps

module dss_ctrl #(
   parameter int DEPTH = 16,
   parameter int AW    = 4,
   parameter int DW    = 5
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       cmd_valid,
   input  logic [dss_pkg::CMD_W-1:0]  cmd_code,
   input  logic                       cmd_stack,
   input  logic [dss_pkg::POS_W-1:0]  cmd_pos,
   input  logic [dss_pkg::DATA_W-1:0] cmd_data,
   output dss_pkg::mem_ctl_type       mem_ctl,
   output logic [AW-1:0]              mem_addr,
   output logic [dss_pkg::DATA_W-1:0] mem_wdata,
   output logic                       rsp_valid,
   output logic                       rsp_rd_ok,
   output logic [dss_pkg::STAT_W-1:0] rsp_status,
   output logic [dss_pkg::CNT_W-1:0]  rsp_lower,
   output logic [dss_pkg::CNT_W-1:0]  rsp_upper
);

   // Wide enough to compare a position against a depth and to form an index.
   localparam int XW = DW + dss_pkg::POS_W;

   logic [DW-1:0]              lower_ff, lower_in;
   logic [DW-1:0]              upper_ff, upper_in;
   logic                       valid_ff;
   logic                       rd_ok_ff, rd_ok_in;
   logic [dss_pkg::STAT_W-1:0] status_ff, status_in;

   logic [DW-1:0] depth_sel;
   logic [DW:0]   total;
   logic          full;
   logic          bad_pos;
   logic [XW-1:0] eff_pos;
   logic [XW-1:0] idx_x;

   always_comb begin
      depth_sel = cmd_stack ? upper_ff : lower_ff;
      total     = {1'b0, lower_ff} + {1'b0, upper_ff};
      full      = (total >= (DW+1)'(DEPTH));
      bad_pos   = (cmd_pos == '0) || (XW'(cmd_pos) > XW'(depth_sel));

      // A push addresses the free slot next to the top, a pop the top itself.
      case (cmd_code)
         dss_pkg::CMD_PUSH: eff_pos = '0;
         dss_pkg::CMD_POP:  eff_pos = XW'(1);
         default:           eff_pos = XW'(cmd_pos);
      endcase

      if (cmd_stack) begin
         idx_x = XW'(DEPTH) - XW'(upper_ff) + eff_pos - XW'(1);
      end else begin
         idx_x = XW'(lower_ff) - eff_pos;
      end
   end

   assign mem_addr  = idx_x[AW-1:0];
   assign mem_wdata = cmd_data;

   always_comb begin
      mem_ctl   = '0;
      status_in = dss_pkg::ST_OK;
      rd_ok_in  = 1'b0;
      lower_in  = lower_ff;
      upper_in  = upper_ff;
      if (cmd_valid) begin
         case (cmd_code)
            dss_pkg::CMD_PUSH: begin
               if (full) begin
                  status_in = dss_pkg::ST_OVERFLOW;
               end else begin
                  mem_ctl.wr = 1'b1;
                  if (cmd_stack) begin
                     upper_in = upper_ff + DW'(1);
                  end else begin
                     lower_in = lower_ff + DW'(1);
                  end
               end
            end
            dss_pkg::CMD_POP: begin
               if (depth_sel == '0) begin
                  status_in = dss_pkg::ST_UNDERFLOW;
               end else begin
                  mem_ctl.rd = 1'b1;
                  rd_ok_in   = 1'b1;
                  if (cmd_stack) begin
                     upper_in = upper_ff - DW'(1);
                  end else begin
                     lower_in = lower_ff - DW'(1);
                  end
               end
            end
            dss_pkg::CMD_PEEK: begin
               if (bad_pos) begin
                  status_in = dss_pkg::ST_RANGE;
               end else begin
                  mem_ctl.rd = 1'b1;
                  rd_ok_in   = 1'b1;
               end
            end
            dss_pkg::CMD_CHANGE: begin
               if (bad_pos) begin
                  status_in = dss_pkg::ST_RANGE;
               end else begin
                  mem_ctl.wr = 1'b1;
               end
            end
            default: begin
               status_in = dss_pkg::ST_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff  <= '0;
         upper_ff  <= '0;
         valid_ff  <= 1'b0;
         rd_ok_ff  <= 1'b0;
         status_ff <= dss_pkg::ST_OK;
      end else begin
         lower_ff  <= lower_in;
         upper_ff  <= upper_in;
         valid_ff  <= cmd_valid;
         rd_ok_ff  <= rd_ok_in;
         status_ff <= status_in;
      end
   end

   // The depth registers hold this command's result during its response cycle.
   assign rsp_valid  = valid_ff;
   assign rsp_rd_ok  = rd_ok_ff;
   assign rsp_status = status_ff;
   assign rsp_lower  = dss_pkg::CNT_W'(lower_ff);
   assign rsp_upper  = dss_pkg::CNT_W'(upper_ff);

endmodule

### rtl/core/dual_stack_shared_memory.sv
`timescale 1ns / 1ps
// Response words come from the pointer logic's output registers after the command register.
// Throughput: one command per cycle; busy stays low, since each command uses a
// single access of the shared memory port and the next command sees updated depths.
// Reset (synchronous, active high) empties both stacks and clears the pipeline.
// Memory contents are not reset. The receiver cannot stall the response strobe.

module dual_stack_shared_memory #(
   parameter int DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [dss_pkg::CMD_W-1:0]         req_command,
   input  logic                              req_which_stack,
   input  logic [dss_pkg::POS_W-1:0]         req_position,
   input  logic signed [dss_pkg::DATA_W-1:0] req_value,
   output logic                              rsp_valid,
   output logic signed [dss_pkg::DATA_W-1:0] rsp_read_value,
   output logic [dss_pkg::STAT_W-1:0]        rsp_status,
   output logic [dss_pkg::CNT_W-1:0]         rsp_lower_count,
   output logic [dss_pkg::CNT_W-1:0]         rsp_upper_count
);

   // Address width of the shared array, and width of a depth counter that
   // must also hold DEPTH itself when one stack fills the whole array.
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int DW = $clog2(DEPTH + 1);

   // Stage one: the accepted command word is registered so that the pointer
   // arithmetic and the memory address start from clean flops.
   logic                       cmd_valid_ff;
   logic [dss_pkg::CMD_W-1:0]  cmd_code_ff;
   logic                       cmd_stack_ff;
   logic [dss_pkg::POS_W-1:0]  cmd_pos_ff;
   logic [dss_pkg::DATA_W-1:0] cmd_data_ff;

   dss_pkg::mem_ctl_type       mem_ctl;
   logic [AW-1:0]              mem_addr;
   logic [dss_pkg::DATA_W-1:0] mem_wdata;
   logic [dss_pkg::DATA_W-1:0] mem_rdata;
   logic                       rd_ok;

   // Every command passes through the stages without stalling, so a new word can
   // always be taken.
   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
      end else begin
         cmd_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         cmd_code_ff  <= req_command;
         cmd_stack_ff <= req_which_stack;
         cmd_pos_ff   <= req_position;
         cmd_data_ff  <= req_value;
      end
   end

   // Stage two: the pointer logic checks the command against both depths,
   // drives at most one read or write of the shared array and updates the depths.
   // Consecutive commands never conflict: a read is registered only after the
   // previous command's write has landed, and the depths it uses are already
   // updated.
   dss_ctrl #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .DW    (DW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid_ff),
      .cmd_code   (cmd_code_ff),
      .cmd_stack  (cmd_stack_ff),
      .cmd_pos    (cmd_pos_ff),
      .cmd_data   (cmd_data_ff),
      .mem_ctl    (mem_ctl),
      .mem_addr   (mem_addr),
      .mem_wdata  (mem_wdata),
      .rsp_valid  (rsp_valid),
      .rsp_rd_ok  (rd_ok),
      .rsp_status (rsp_status),
      .rsp_lower  (rsp_lower_count),
      .rsp_upper  (rsp_upper_count)
   );

   dss_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock (clock),
      .ctl   (mem_ctl),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   // Stage three: the read data register feeds the response word directly.
   // Only a successful pop or peek returns data; everything else reads zero.
   assign rsp_read_value = rd_ok ? signed'(mem_rdata) : '0;

endmodule

### rtl/core/dss_check.sv
`timescale 1ns / 1ps

module dss_check (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic                              rsp_valid,
   input logic signed [dss_pkg::DATA_W-1:0] rsp_read_value,
   input logic [dss_pkg::STAT_W-1:0]        rsp_status
);

   // Commands are never held off.
   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      !busy)
      else $error("busy asserted");

   // Every accepted word is answered by a response strobe.
   a_accept_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("accepted word got no response");

   // No response without a matching accepted command.
   a_rsp_has_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("response without command");

   // A refused command returns no data.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != dss_pkg::ST_OK)) |-> (rsp_read_value == '0))
      else $error("refused command returned data");

endmodule

bind dual_stack_shared_memory dss_check u_check (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_read_value (rsp_read_value),
   .rsp_status     (rsp_status)
);

### tb/sv/dss_checker.sv
`timescale 1ns / 1ps

module dss_checker
   import dss_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  logic [CMD_W-1:0]          req_command,
   input  logic                      req_which_stack,
   input  logic [POS_W-1:0]          req_position,
   input  logic signed [DATA_W-1:0]  req_value,
   input  logic                      rsp_valid,
   input  logic signed [DATA_W-1:0]  rsp_read_value,
   input  logic [STAT_W-1:0]         rsp_status,
   input  logic [CNT_W-1:0]          rsp_lower_count,
   input  logic [CNT_W-1:0]          rsp_upper_count,
   output int                        mismatches,
   output int                        outstanding,
   output int                        replies_checked,
   output int                        lower_fill,
   output int                        upper_fill
);

   typedef struct packed {
      logic signed [DATA_W-1:0] read_value;
      logic [STAT_W-1:0]        status;
      logic [CNT_W-1:0]         lower_count;
      logic [CNT_W-1:0]         upper_count;
   } stack_reply_t;

   stack_reply_t             expected_replies[$];
   logic signed [DATA_W-1:0] shared_words[DEPTH];
   int                       lower_level = 0;
   int                       upper_level = 0;
   int                       error_total = 0;
   int                       pending_total = 0;
   int                       checked_total = 0;

   assign mismatches      = error_total;
   assign outstanding     = pending_total;
   assign replies_checked = checked_total;
   assign lower_fill      = lower_level;
   assign upper_fill      = upper_level;

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] want);
      error_total++;
      $display("[%0t] mismatch in %s: got %0h, expected %0h", $time, what, got, want);
   endtask

   // Applies one command to the shadow stacks and returns the reply it should produce.
   function automatic stack_reply_t apply_stack_command(input logic [CMD_W-1:0] cmd,
                                                        input logic stk,
                                                        input logic [POS_W-1:0] pos,
                                                        input logic signed [DATA_W-1:0] val);
      stack_reply_t reply;
      int           fill;
      int           slot;
      reply = '0;
      fill  = stk ? upper_level : lower_level;
      case (cmd)
         CMD_PUSH: begin
            if (lower_level + upper_level >= DEPTH) begin
               reply.status = ST_OVERFLOW;
            end else if (!stk) begin
               shared_words[lower_level] = val;
               lower_level++;
            end else begin
               upper_level++;
               shared_words[DEPTH - upper_level] = val;
            end
         end
         CMD_POP: begin
            if (fill == 0) begin
               reply.status = ST_UNDERFLOW;
            end else if (!stk) begin
               reply.read_value = shared_words[lower_level - 1];
               lower_level--;
            end else begin
               reply.read_value = shared_words[DEPTH - upper_level];
               upper_level--;
            end
         end
         default: begin
            if (int'(pos) == 0 || int'(pos) > fill) begin
               reply.status = ST_RANGE;
            end else begin
               slot = stk ? DEPTH - upper_level + int'(pos) - 1 : lower_level - int'(pos);
               if (cmd == CMD_PEEK) begin
                  reply.read_value = shared_words[slot];
               end else begin
                  shared_words[slot] = val;
               end
            end
         end
      endcase
      reply.lower_count = lower_level[CNT_W-1:0];
      reply.upper_count = upper_level[CNT_W-1:0];
      return reply;
   endfunction

   always @(posedge clock) begin
      stack_reply_t want;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_replies.size() == 0) begin
               report_mismatch("response word with nothing expected",
                               DATA_W'(rsp_status), '0);
            end else begin
               want = expected_replies.pop_front();
               if (rsp_read_value !== want.read_value)
                  report_mismatch("read_value", rsp_read_value, want.read_value);
               if (rsp_status !== want.status)
                  report_mismatch("status", DATA_W'(rsp_status), DATA_W'(want.status));
               if (rsp_lower_count !== want.lower_count)
                  report_mismatch("lower_count", DATA_W'(rsp_lower_count),
                                  DATA_W'(want.lower_count));
               if (rsp_upper_count !== want.upper_count)
                  report_mismatch("upper_count", DATA_W'(rsp_upper_count),
                                  DATA_W'(want.upper_count));
               checked_total++;
            end
         end
         if (start && !busy) begin
            expected_replies.push_back(apply_stack_command(req_command, req_which_stack,
                                                           req_position, req_value));
         end
         pending_total = expected_replies.size();
      end
   end

endmodule

### tb/sv/tb_dual_stack_shared_memory.sv
`timescale 1ns / 1ps

module tb_dual_stack_shared_memory;
   import dss_pkg::*;

   localparam int DEPTH        = 16;
   localparam int RANDOM_ITEMS = 1900;
   localparam int PHASES       = 4;
   localparam int CHUNK        = 48;
   // Worst quiet stretch comes from a long run of sender idle cycles at the
   // 84 percent setting; this limit is far beyond any plausible gap.
   localparam int STALL_LIMIT  = 2000;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic [CMD_W-1:0]          req_command;
   logic                      req_which_stack;
   logic [POS_W-1:0]          req_position;
   logic signed [DATA_W-1:0]  req_value;
   logic                      rsp_valid;
   logic signed [DATA_W-1:0]  rsp_read_value;
   logic [STAT_W-1:0]         rsp_status;
   logic [CNT_W-1:0]          rsp_lower_count;
   logic [CNT_W-1:0]          rsp_upper_count;

   int mismatches;
   int outstanding;
   int replies_checked;
   int lower_fill;
   int upper_fill;

   // Percentage of cycles in which the sender holds back before a word.
   int idle_pct;
   int command_tally[4];
   int quiet_cycles;
   int phase_idle[PHASES] = '{0, 84, 6, 0};

   // The clock runs with a 20 ns period, low half first.
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   dual_stack_shared_memory #(
      .DEPTH(DEPTH)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_command    (req_command),
      .req_which_stack(req_which_stack),
      .req_position   (req_position),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_lower_count(rsp_lower_count),
      .rsp_upper_count(rsp_upper_count)
   );

   // The checker watches both channels, keeps its own copy of the two stacks,
   // and hands back the failure count together with its view of the fill levels.
   dss_checker #(
      .DEPTH(DEPTH)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_command    (req_command),
      .req_which_stack(req_which_stack),
      .req_position   (req_position),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_lower_count(rsp_lower_count),
      .rsp_upper_count(rsp_upper_count),
      .mismatches     (mismatches),
      .outstanding    (outstanding),
      .replies_checked(replies_checked),
      .lower_fill     (lower_fill),
      .upper_fill     (upper_fill)
   );

   // The watchdog counts cycles in which no word moves on either channel. If the
   // block hangs, the run ends here instead of waiting forever.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog expired after %0d quiet cycles.", quiet_cycles);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // Sends one command word. Inputs change only at the falling edge; while the
   // sender idles, the fields carry random junk with start low, which the block
   // must ignore. The task returns at the falling edge after acceptance, leaving
   // start high so that back-to-back words follow each other without a gap.
   task automatic issue_word(input logic [CMD_W-1:0] cmd, input logic stk,
                             input logic [POS_W-1:0] pos,
                             input logic signed [DATA_W-1:0] val);
      while ($urandom_range(0, 99) < idle_pct) begin
         start           = 1'b0;
         req_command     = CMD_W'($urandom);
         req_which_stack = 1'($urandom);
         req_position    = POS_W'($urandom);
         req_value       = $urandom;
         @(negedge clock);
      end
      start           = 1'b1;
      req_command     = cmd;
      req_which_stack = stk;
      req_position    = pos;
      req_value       = val;
      command_tally[cmd]++;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // Holds the sender off until every response word that is owed has arrived.
   task automatic drain_responses();
      start = 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   // Builds one random command. The push weight steers the stacks toward full or
   // toward empty, and the lower weight decides how often the lower stack is
   // addressed. Most positions fall inside the addressed stack so that peeks and
   // changes reach deep entries; the rest are arbitrary and mostly out of range.
   task automatic random_word(input int push_weight, input int lower_weight);
      logic [CMD_W-1:0]         cmd;
      logic                     stk;
      logic [POS_W-1:0]         pos;
      logic signed [DATA_W-1:0] val;
      int                       pick;
      int                       fill;
      pick = $urandom_range(0, 99);
      if (pick < push_weight) begin
         cmd = CMD_PUSH;
      end else if (pick < 70) begin
         cmd = CMD_POP;
      end else if (pick < 85) begin
         cmd = CMD_PEEK;
      end else begin
         cmd = CMD_CHANGE;
      end
      stk  = ($urandom_range(0, 99) >= lower_weight);
      fill = stk ? upper_fill : lower_fill;
      if (fill == 0 || $urandom_range(0, 9) == 0) begin
         pos = POS_W'($urandom_range(0, 31));
      end else begin
         pos = POS_W'($urandom_range(1, fill));
      end
      case ($urandom_range(0, 15))
         0:       val = '0;
         1:       val = -1;
         2:       val = 32'sh7FFF_FFFF;
         3:       val = 32'sh8000_0000;
         default: val = $urandom;
      endcase
      issue_word(cmd, stk, pos, val);
   endtask

   initial begin
      int push_weight;
      int lower_weight;
      reset           = 1'b1;
      start           = 1'b0;
      req_command     = CMD_PUSH;
      req_which_stack = 1'b0;
      req_position    = '0;
      req_value       = '0;
      idle_pct        = 0;
      quiet_cycles    = 0;
      push_weight     = 55;
      lower_weight    = 50;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part. Both stacks start empty, so pops underflow and any
      // position is out of range, including position zero and the largest
      // position the field can carry.
      issue_word(CMD_POP,    1'b0, 5'd3,  32'sh1234_5678);
      issue_word(CMD_POP,    1'b1, 5'd0,  -1);
      issue_word(CMD_PEEK,   1'b1, 5'd0,  -1);
      issue_word(CMD_CHANGE, 1'b0, 5'd31, 32'sh7FFF_FFFF);
      // The extreme data values go onto one stack each, and the position field
      // of a push carries junk that must be ignored.
      issue_word(CMD_PUSH,   1'b0, 5'd31, 32'sh7FFF_FFFF);
      issue_word(CMD_PUSH,   1'b1, 5'd17, 32'sh8000_0000);
      issue_word(CMD_PEEK,   1'b0, 5'd1,  '0);
      issue_word(CMD_PEEK,   1'b1, 5'd2,  '0);
      issue_word(CMD_CHANGE, 1'b1, 5'd1,  -1);
      issue_word(CMD_PEEK,   1'b1, 5'd1,  32'sh5555_5555);
      // Fill the shared memory from both ends until it is full, then try one
      // push on each stack; both must report overflow and change nothing.
      for (int k = 0; k < DEPTH - 2; k++) begin
         issue_word(CMD_PUSH, 1'(k), POS_W'(k), $urandom);
      end
      issue_word(CMD_PUSH,   1'b0, 5'd0,  32'sh0F0F_0F0F);
      issue_word(CMD_PUSH,   1'b1, 5'd0,  32'shF0F0_F0F0);
      issue_word(CMD_PEEK,   1'b0, 5'd8,  '0);
      // At least once the sender waits for every owed response word.
      drain_responses();

      // Random part, in phases of different sender idling. Within a phase the
      // bias swings between filling and draining so that the fill levels sweep
      // across their whole range, with the split between stacks varied.
      for (int p = 0; p < PHASES; p++) begin
         idle_pct = phase_idle[p];
         for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) begin
            if (i % CHUNK == 0) begin
               push_weight  = ((i / CHUNK) % 2 == 0) ? 55 : 15;
               lower_weight = $urandom_range(10, 90);
            end
            random_word(push_weight, lower_weight);
         end
         drain_responses();
      end

      // Every response word has arrived; waiting on after that catches any stray strobe.
      repeat (4) @(negedge clock);

      $display("Covered %0d pushes, %0d pops, %0d peeks and %0d changes,",
               command_tally[CMD_PUSH], command_tally[CMD_POP],
               command_tally[CMD_PEEK], command_tally[CMD_CHANGE]);
      $display("with sender idling at 0, 84 and 6 percent; %0d response words checked.",
               replies_checked);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
